@@ rtl/top_n_volume_ranker_unit_assert.svh @@
// Assertion macros used by the ranker unit's RTL file.
`ifndef TOP_N_VOLUME_RANKER_UNIT_ASSERT_SVH
`define TOP_N_VOLUME_RANKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TNVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TNVR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define TNVR_ASSERT(lbl, prop, msg)
`define TNVR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/tnvr_pkg.sv @@
// Types and constants of the top-N volume ranker.
package tnvr_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned MaxTop       = 16;
  localparam int unsigned SymW         = 64;
  localparam int unsigned VolW         = 32;
  localparam int unsigned TotW         = 48;
  localparam int unsigned RankW        = 4;
  localparam int unsigned CfgW         = 5;
  localparam logic [CfgW-1:0] TopCountReset = 5'd4;

  typedef struct packed {
    logic [SymW-1:0] symbol_code;
    logic [VolW-1:0] share_count;
  } trade_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [SymW-1:0]  ranked_symbol;
    logic [TotW-1:0]  total_volume;
    logic             trade_dropped;
    logic             last_of_list;
  } result_t;

  // One ranked entry as held in the store, kept in rank order.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic [TotW-1:0] total;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRD, ST_SCMP, ST_NEW, ST_BRD, ST_BCMP, ST_BFIN,
    ST_EINIT, ST_ERD, ST_EOUT
  } state_e;
endpackage

@@ rtl/tnvr_store.sv @@
// Ranked entry memory: one write port, one registered read port.
module tnvr_store import tnvr_pkg::*; #(
  parameter int unsigned Depth = TableEntries
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);
  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/top_n_volume_ranker_unit.sv @@
// Top-N volume ranker: entries live in one memory held in descending order of total. A
// trade scans the memory from the top for its symbol, appends a new symbol at the
// bottom, then moves the entry upward past smaller totals, and finally reads out the
// top entries. These steps run one after another, as the entry memory has a single
// read port. Input is taken only between trades; the last result item may still wait
// at the output while the next item is accepted. A new symbol arriving with the table
// full is not stored and every item of that trade carries trade_dropped.
`include "top_n_volume_ranker_unit_assert.svh"
module top_n_volume_ranker_unit import tnvr_pkg::*; #(
  parameter int unsigned TableEntriesP = TableEntries,
  parameter int unsigned MaxTopP       = MaxTop
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  trade_t          in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_data_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i
);
  localparam int unsigned IdxW = $clog2(TableEntriesP);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned NW   = $clog2(MaxTopP + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [NW-1:0]   n_q, n_d;
  logic [CfgW-1:0] top_q;
  logic [SymW-1:0] sym_q, sym_d;
  logic [VolW-1:0] vol_q, vol_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic            drop_q, drop_d;
  logic            ovalid_q, ovalid_d;
  result_t         odata_q, odata_d;

  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic [TotW:0]   sum;
  logic [TotW-1:0] sat_sum;
  logic            match, last_scan, at_top, full, out_free, last_item;
  logic [31:0]     tc, n_full;

  tnvr_store #(.Depth(TableEntriesP)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sum       = {1'b0, rdata.total} + (TotW+1)'(vol_q);
  assign sat_sum   = sum[TotW] ? {TotW{1'b1}} : sum[TotW-1:0];
  assign match     = (rdata.symbol == sym_q);
  assign last_scan = (CntW'(pos_q) + CntW'(1) == cnt_q);
  assign at_top    = (pos_q == '0);
  assign full      = (cnt_q == CntW'(TableEntriesP));
  assign out_free  = !ovalid_q || out_ready_i;
  assign last_item = (32'(pos_q) + 32'd1 == 32'(n_q));

  // Clamp top_count to 1..MaxTop, then to the number of entries.
  always_comb begin
    tc = (top_q == '0) ? 32'd1 : 32'(top_q);
    if (tc > MaxTopP) begin
      tc = MaxTopP;
    end
    n_full = (32'(cnt_q) < tc) ? 32'(cnt_q) : tc;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = (cnt_q == '0) ? ST_NEW : ST_SRD;
      ST_SRD:   state_d = ST_SCMP;
      ST_SCMP: begin
        if (match) state_d = at_top ? ST_BFIN : ST_BRD;
        else if (last_scan) state_d = ST_NEW;
        else state_d = ST_SRD;
      end
      ST_NEW: begin
        if (full) state_d = ST_EINIT;
        else state_d = (cnt_q == '0) ? ST_BFIN : ST_BRD;
      end
      ST_BRD:   state_d = ST_BCMP;
      ST_BCMP: begin
        if (rdata.total < tot_q) state_d = (pos_q == IdxW'(1)) ? ST_BFIN : ST_BRD;
        else state_d = ST_EINIT;
      end
      ST_BFIN:  state_d = ST_EINIT;
      ST_EINIT: state_d = ST_ERD;
      ST_ERD:   state_d = ST_EOUT;
      ST_EOUT:  if (out_free) state_d = last_item ? ST_IDLE : ST_ERD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    n_d      = n_q;
    sym_d    = sym_q;
    vol_d    = vol_q;
    tot_d    = tot_q;
    drop_d   = drop_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = '{symbol: sym_q, total: tot_q};
    re       = 1'b0;
    raddr    = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sym_d  = in_data_i.symbol_code;
          vol_d  = in_data_i.share_count;
          pos_d  = '0;
          drop_d = 1'b0;
        end
      end
      ST_SRD: re = 1'b1;
      ST_SCMP: begin
        if (match) tot_d = sat_sum;
        else if (!last_scan) pos_d = pos_q + IdxW'(1);
      end
      ST_NEW: begin
        if (full) begin
          drop_d = 1'b1;
        end else begin
          pos_d = cnt_q[IdxW-1:0];
          tot_d = TotW'(vol_q);
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_BRD: begin
        re    = 1'b1;
        raddr = pos_q - IdxW'(1);
      end
      ST_BCMP: begin
        we = 1'b1;
        if (rdata.total < tot_q) begin
          wdata = rdata;
          pos_d = pos_q - IdxW'(1);
        end
      end
      ST_BFIN: we = 1'b1;
      ST_EINIT: begin
        pos_d = '0;
        n_d   = NW'(n_full);
      end
      ST_ERD: re = 1'b1;
      ST_EOUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = '{rank: pos_q[RankW-1:0], ranked_symbol: rdata.symbol,
                       total_volume: rdata.total, trade_dropped: drop_q,
                       last_of_list: last_item};
          if (!last_item) pos_d = pos_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      top_q    <= TopCountReset;
      ovalid_q <= 1'b0;
      pos_q    <= '0;
      n_q      <= '0;
      drop_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      pos_q    <= pos_d;
      n_q      <= n_d;
      drop_q   <= drop_d;
      if (cfg_we_i) top_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    vol_q   <= vol_d;
    tot_q   <= tot_d;
    odata_q <= odata_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  `TNVR_ASSERT(a_cnt_bound, cnt_q <= CntW'(TableEntriesP), "entry count beyond table size")
  `TNVR_ASSERT(a_no_idle_write, !(state_q == ST_IDLE && we), "memory written while idle")
  `TNVR_ASSERT_NEXT(a_cnt_step, 1'b1, cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CntW'(1), "entry count moved by more than one")
endmodule

@@ sim/tnvr_checker.sv @@
// Checker for the top-N volume ranker: predicts every result item and compares it.
`timescale 1ns / 100ps
module tnvr_checker import tnvr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  trade_t          in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  result_t         out_data_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);
  logic [SymW-1:0] sym_tab [TableEntries];
  logic [TotW-1:0] tot_tab [TableEntries];
  int unsigned     order   [TableEntries];
  int unsigned     n_entries;
  logic [CfgW-1:0] top_setting;
  result_t         ranking_q[$];

  assign pending_o = ranking_q.size();

  // Applies one trade to the shadow table and queues the ranking it produces.
  task automatic rank_trade(input trade_t tr);
    int unsigned     pos, found, idx, n;
    logic [TotW:0]   sum;
    logic            dropped;
    result_t         r;
    dropped = 1'b0;
    found = n_entries;
    for (int unsigned i = 0; i < n_entries; i++)
      if (sym_tab[order[i]] == tr.symbol_code) begin
        found = i;
        break;
      end
    if (found < n_entries) begin
      pos = found;
      idx = order[pos];
      sum = {1'b0, tot_tab[idx]} + (TotW+1)'(tr.share_count);
      tot_tab[idx] = sum[TotW] ? '1 : sum[TotW-1:0];
    end else if (n_entries < TableEntries) begin
      idx = n_entries;
      pos = idx;
      sym_tab[idx] = tr.symbol_code;
      tot_tab[idx] = TotW'(tr.share_count);
      order[idx] = idx;
      n_entries++;
    end else begin
      dropped = 1'b1;
    end
    if (!dropped) begin
      // Equal totals stay ahead, so only strictly smaller ones are passed.
      while (pos > 0 && tot_tab[order[pos-1]] < tot_tab[idx]) begin
        order[pos] = order[pos-1];
        pos--;
      end
      order[pos] = idx;
    end
    n = top_setting;
    if (n < 1) n = 1;
    if (n > MaxTop) n = MaxTop;
    if (n > n_entries) n = n_entries;
    for (int unsigned p = 0; p < n; p++) begin
      r.rank          = RankW'(p);
      r.ranked_symbol = sym_tab[order[p]];
      r.total_volume  = tot_tab[order[p]];
      r.trade_dropped = dropped;
      r.last_of_list  = (p + 1 == n);
      ranking_q = {ranking_q, r};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      n_entries    = 0;
      top_setting  <= TopCountReset;
      fail_count_o <= 0;
      ranking_q.delete();
    end else begin
      if (cfg_we_i) top_setting <= cfg_data_i;
      if (in_valid_i && in_ready_i) rank_trade(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (ranking_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = ranking_q.pop_front();
          if (out_data_i !== exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Stimulus and verdict for the top-N volume ranker testbench.
`timescale 1ns / 100ps
module tb_top;
  import tnvr_pkg::*;

  logic            clk_i, rst_ni;
  logic            in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  trade_t          in_data_i;
  result_t         out_data_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;
  int              fail_count, pending;
  logic            hold_off;
  logic [SymW-1:0] symbol_pool [24];

  top_n_volume_ranker_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  tnvr_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: stalls on its own pattern, with one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (150) @(negedge clk_i);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  task automatic send_trade(input logic [SymW-1:0] sym, input logic [VolW-1:0] vol);
    in_valid_i <= 1'b1;
    in_data_i  <= '{symbol_code: sym, share_count: vol};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    // Random gap between bursts; most of the time the next item follows at once.
    if ($urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_top(input logic [CfgW-1:0] val);
    drain(600);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [SymW-1:0] s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    hold_off = 1'b0;
    for (int i = 0; i < 24; i++)
      symbol_pool[i] = {$urandom, $urandom};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, zero shares, equal totals, new symbols.
    send_trade('0, 32'd0);
    send_trade('1, '1);
    send_trade(64'h5A5A_5A5A_5A5A_5A5A, 32'd5);
    send_trade(64'hA5A5_A5A5_A5A5_A5A5, 32'd5);
    send_trade(64'h5A5A_5A5A_5A5A_5A5A, 32'd0);
    send_trade('0, 32'd5);
    send_trade(64'h4142_4300_0000_0000, 32'd0);
    send_trade(64'hA5A5_A5A5_A5A5_A5A5, '1);
    set_top(5'd0);
    send_trade(64'h5A5A_5A5A_5A5A_5A5A, 32'd3);
    set_top(5'd31);
    send_trade(64'h4142_4300_0000_0000, 32'd100);
    set_top(5'd16);
    send_trade('0, 32'd1);
    set_top(5'd1);
    send_trade(64'h1, 32'd1);

    // Long receiver hold-off while the sender keeps offering items.
    set_top(5'd16);
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_trade(symbol_pool[$urandom_range(0, 23)], $urandom_range(0, 1000));
    drain(0);

    // Random trades, mostly from a small pool so totals climb and ranks shift.
    for (int i = 0; i < 78; i++) begin
      if (i == 40) set_top(5'($urandom_range(2, 15)));
      s = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : symbol_pool[$urandom_range(0, 23)];
      send_trade(s, ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 500));
    end

    drain(600);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/tnvr_pkg.sv
rtl/tnvr_store.sv
rtl/top_n_volume_ranker_unit.sv
sim/tnvr_checker.sv
sim/tb_top.sv
